FILE: hw/rtl/pal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pal_pkg
// shared constants and codes of the positional array list
// ----------------------------------------------------------------------------
package pal_pkg;

  // list storage
  localparam int unsigned DEPTH = 64;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // field widths
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned STAT_W  = 2;

  // full count as a count-wide value
  localparam logic [POS_W-1:0] DEPTH_CNT = POS_W'(DEPTH);

  // operation codes
  localparam logic [MODE_W-1:0] MODE_APPEND      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE_LAST = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT_AT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE_AT   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ_ALL    = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd3;

endpackage
`default_nettype wire

FILE: hw/rtl/pal_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pal_mem
// list storage, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module pal_mem (
  input  wire logic                               clk_i,
  input  wire logic                               we_i,
  input  wire logic [pal_pkg::AW-1:0]             waddr_i,
  input  wire logic signed [pal_pkg::DATA_W-1:0]  wdata_i,
  input  wire logic [pal_pkg::AW-1:0]             raddr_i,
  output logic signed [pal_pkg::DATA_W-1:0]       rdata_o
);
  import pal_pkg::*;

  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hw/rtl/positional_array_list_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_array_list_unit
// ordered list of signed words with append, remove, positional insert and
// remove, and full read-out, sequenced over a single-port-pair memory
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. Results come one
// per cycle on the result ports, each marked by valid_o for exactly one cycle,
// and the receiver cannot stall them: sample every cycle that valid_o is high.
// Append, and insert at the current end, finish at once (result the
// following cycle, busy never rises). Remove last reads the top word, then
// reports it. Insert at a position moves each word above it one up, then
// writes the new word; remove at a position reads the word, then moves each
// word above it one down. Every shifted word makes one pass through the
// memory's read port and one through its write port. Read all gives count
// results back to back after the registered memory read. Errors and unused
// modes finish at once. The last result of every operation has last_o set.
// ----------------------------------------------------------------------------
module positional_array_list_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [pal_pkg::MODE_W-1:0]         mode_i,
  input  wire logic signed [pal_pkg::DATA_W-1:0]  value_in_i,
  input  wire logic [pal_pkg::POS_W-1:0]          position_in_i,
  output logic                                    valid_o,
  output logic [pal_pkg::STAT_W-1:0]              status_o,
  output logic signed [pal_pkg::DATA_W-1:0]       value_out_o,
  output logic [pal_pkg::POS_W-1:0]               position_out_o,
  output logic [pal_pkg::POS_W-1:0]               count_out_o,
  output logic                                    last_o
);
  import pal_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RD_LAST  = 3'd1;
  localparam logic [2:0] S_SHIFT_UP = 3'd2;
  localparam logic [2:0] S_INS_WR   = 3'd3;
  localparam logic [2:0] S_DEL_HEAD = 3'd4;
  localparam logic [2:0] S_SHIFT_DN = 3'd5;
  localparam logic [2:0] S_READ_ALL = 3'd6;

  logic [2:0]               state_q, state_d;
  logic [POS_W-1:0]         cnt_q, cnt_d;     // words held
  logic [POS_W-1:0]         ptr_q, ptr_d;     // walking index
  logic [POS_W-1:0]         pos_q, pos_d;     // position of the operation
  logic signed [DATA_W-1:0] val_q, val_d;     // word inserted or removed

  // memory ports
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]            mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;

  // result before the output register
  logic                     res_valid;
  logic [STAT_W-1:0]        res_status;
  logic signed [DATA_W-1:0] res_value;
  logic [POS_W-1:0]         res_pos;
  logic [POS_W-1:0]         res_count;
  logic                     res_last;

  // output register
  logic                     valid_q;
  logic [STAT_W-1:0]        status_q;
  logic signed [DATA_W-1:0] value_q;
  logic [POS_W-1:0]         position_q;
  logic [POS_W-1:0]         count_q;
  logic                     last_q;

  // index arithmetic around the walking pointer
  logic [POS_W-1:0] cnt_m1, ptr_m1, ptr_m2, ptr_p1, ptr_p2;
  logic             accept;

  assign cnt_m1 = cnt_q - POS_W'(1);
  assign ptr_m1 = ptr_q - POS_W'(1);
  assign ptr_m2 = ptr_q - POS_W'(2);
  assign ptr_p1 = ptr_q + POS_W'(1);
  assign ptr_p2 = ptr_q + POS_W'(2);

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  pal_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ptr_d      = ptr_q;
    pos_d      = pos_q;
    val_d      = val_q;
    mem_we     = 1'b0;
    mem_waddr  = ptr_q[AW-1:0];
    mem_wdata  = mem_rdata;
    mem_raddr  = '0;
    res_valid  = 1'b0;
    res_status = STAT_OK;
    res_value  = '0;
    res_pos    = '0;
    res_count  = cnt_q;
    res_last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          pos_d = position_in_i;
          val_d = value_in_i;
          unique case (mode_i)
            MODE_APPEND: begin
              res_valid = 1'b1;
              if (cnt_q >= DEPTH_CNT) begin
                res_status = STAT_FULL;
              end else begin
                // write straight at the end
                mem_we    = 1'b1;
                mem_waddr = cnt_q[AW-1:0];
                mem_wdata = value_in_i;
                cnt_d     = cnt_q + POS_W'(1);
                res_value = value_in_i;
                res_pos   = cnt_q;
                res_count = cnt_d;
              end
            end
            MODE_REMOVE_LAST: begin
              if (cnt_q == '0) begin
                res_valid  = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                mem_raddr = cnt_m1[AW-1:0];
                state_d   = S_RD_LAST;
              end
            end
            MODE_INSERT_AT: begin
              if (cnt_q >= DEPTH_CNT) begin
                res_valid  = 1'b1;
                res_status = STAT_FULL;
                res_pos    = position_in_i;
              end else if (position_in_i > cnt_q) begin
                res_valid  = 1'b1;
                res_status = STAT_BAD_POS;
                res_pos    = position_in_i;
              end else if (position_in_i == cnt_q) begin
                // nothing above to move
                mem_we    = 1'b1;
                mem_waddr = cnt_q[AW-1:0];
                mem_wdata = value_in_i;
                cnt_d     = cnt_q + POS_W'(1);
                res_valid = 1'b1;
                res_value = value_in_i;
                res_pos   = position_in_i;
                res_count = cnt_d;
              end else begin
                // walk down from the top, moving each word one up
                mem_raddr = cnt_m1[AW-1:0];
                ptr_d     = cnt_q;
                state_d   = S_SHIFT_UP;
              end
            end
            MODE_REMOVE_AT: begin
              if (position_in_i >= cnt_q) begin
                res_valid  = 1'b1;
                res_status = STAT_BAD_POS;
                res_pos    = position_in_i;
              end else begin
                mem_raddr = position_in_i[AW-1:0];
                ptr_d     = position_in_i;
                state_d   = S_DEL_HEAD;
              end
            end
            MODE_READ_ALL: begin
              if (cnt_q == '0) begin
                res_valid  = 1'b1;
                res_status = STAT_EMPTY;
                res_count  = '0;
              end else begin
                mem_raddr = '0;
                ptr_d     = '0;
                state_d   = S_READ_ALL;
              end
            end
            default: begin
              // unused codes do nothing
            end
          endcase
        end
      end

      S_RD_LAST: begin
        cnt_d     = cnt_m1;
        res_valid = 1'b1;
        res_value = mem_rdata;
        res_pos   = cnt_m1;
        res_count = cnt_m1;
        state_d   = S_IDLE;
      end

      S_SHIFT_UP: begin
        // word read from ptr - 1 lands at ptr
        mem_we = 1'b1;
        if (ptr_m1 == pos_q) begin
          state_d = S_INS_WR;
        end else begin
          mem_raddr = ptr_m2[AW-1:0];
          ptr_d     = ptr_m1;
        end
      end

      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[AW-1:0];
        mem_wdata = val_q;
        cnt_d     = cnt_q + POS_W'(1);
        res_valid = 1'b1;
        res_value = val_q;
        res_pos   = pos_q;
        res_count = cnt_d;
        state_d   = S_IDLE;
      end

      S_DEL_HEAD: begin
        val_d = mem_rdata;
        if (ptr_p1 >= cnt_q) begin
          // removed word was the top one
          cnt_d     = cnt_m1;
          res_valid = 1'b1;
          res_value = mem_rdata;
          res_pos   = pos_q;
          res_count = cnt_m1;
          state_d   = S_IDLE;
        end else begin
          mem_raddr = ptr_p1[AW-1:0];
          state_d   = S_SHIFT_DN;
        end
      end

      S_SHIFT_DN: begin
        // word read from ptr + 1 lands at ptr
        mem_we = 1'b1;
        ptr_d  = ptr_p1;
        if (ptr_p2 < cnt_q) begin
          mem_raddr = ptr_p2[AW-1:0];
        end else begin
          cnt_d     = cnt_m1;
          res_valid = 1'b1;
          res_value = val_q;
          res_pos   = pos_q;
          res_count = cnt_m1;
          state_d   = S_IDLE;
        end
      end

      S_READ_ALL: begin
        res_valid = 1'b1;
        res_value = mem_rdata;
        res_pos   = ptr_q;
        res_last  = (ptr_p1 == cnt_q);
        mem_raddr = ptr_p1[AW-1:0];
        ptr_d     = ptr_p1;
        if (res_last) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= res_valid;
    end
  end

  // working registers and result payload
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    pos_q <= pos_d;
    val_q <= val_d;
    if (res_valid) begin
      status_q   <= res_status;
      value_q    <= res_value;
      position_q <= res_pos;
      count_q    <= res_count;
      last_q     <= res_last;
    end
  end

  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign value_out_o    = value_q;
  assign position_out_o = position_q;
  assign count_out_o    = count_q;
  assign last_o         = last_q;

  // the list never reports more words than it can hold
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (count_out_o <= DEPTH_CNT))
    else $error("result count beyond list depth");

  // an error always closes its operation
  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o != STAT_OK)) |-> last_o)
    else $error("error result not marked last");

  // an unused mode produces no result
  a_unused_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (mode_i > MODE_READ_ALL)) |=> !valid_o)
    else $error("result for an unused mode");

  // no result may follow a last one while the unit stays idle
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o && !busy && !start) |=> !valid_o)
    else $error("result after the final one of an operation");

endmodule
`default_nettype wire
